@@ src/paillier_pkg.sv @@
// ============================================================================
// paillier_pkg: shared types, constants and helpers
// Widths, stage counts and modular-reduction steps for the Paillier core.
// ============================================================================
`default_nettype none

package paillier_pkg;

  // Key and data widths
  localparam int KEY_BITS     = 8;
  localparam int MOD_W        = 8;
  localparam int SQ_W         = 2 * MOD_W;
  localparam int PROD_W       = 2 * SQ_W;
  localparam int EXP_BITS     = 8;
  localparam int WIDE_W       = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int STEP_BITS    = 8;

  // Pipeline layout
  localparam int REDUCE_STAGES = PROD_W / STEP_BITS;
  localparam int MODMUL_STAGES = 1 + REDUCE_STAGES;
  localparam int ROUND_STAGES  = 2 * MODMUL_STAGES;
  localparam int EXP_STAGES    = EXP_BITS * ROUND_STAGES;
  localparam int DIV_STAGES    = WIDE_W / STEP_BITS;
  localparam int MUL_STAGE     = DIV_STAGES;
  localparam int FIN_STAGES    = 2 * DIV_STAGES + 1;

  localparam logic [MOD_W-1:0] KEY_MASK = MOD_W'((1 << KEY_BITS) - 1);

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS   = 2'd0,
    REG_GENERATOR = 2'd1,
    REG_LAMBDA    = 2'd2,
    REG_MU        = 2'd3
  } cfg_reg_t;

  // Exponentiation stage: lane a (g^m or c^lambda), lane b (r^n)
  typedef struct packed {
    logic              valid;
    action_t           action;
    logic [SQ_W-1:0]   base_a;
    logic [EXP_BITS-1:0] exp_a;
    logic [MOD_W-1:0]  base_b;
    logic [SQ_W-1:0]   acc_a;
    logic [SQ_W-1:0]   acc_b;
    logic [PROD_W-1:0] prod_a;
    logic [PROD_W-1:0] prod_b;
  } exp_st_t;

  // Final stage: encrypt product reduction, decrypt divide and reduce
  typedef struct packed {
    logic              valid;
    action_t           action;
    logic [SQ_W-1:0]   acc_e;
    logic [PROD_W-1:0] prod_e;
    logic [WIDE_W-1:0] dv;
    logic [MOD_W-1:0]  rem;
  } fin_st_t;

  typedef struct packed {
    logic [MOD_W-1:0]  rem;
    logic [WIDE_W-1:0] dv;
  } div_t;

  // Fold eight more product bits into a remainder modulo m
  function automatic logic [SQ_W-1:0] reduce_byte(input logic [SQ_W-1:0] rem,
                                                  input logic [STEP_BITS-1:0] bits,
                                                  input logic [SQ_W-1:0] m);
    logic [SQ_W:0]   t;
    logic [SQ_W-1:0] r;
    r = rem;
    for (int j = STEP_BITS - 1; j >= 0; j--) begin
      t = {r, bits[j]};
      if (t >= {1'b0, m}) begin
        t = t - {1'b0, m};
      end
      r = t[SQ_W-1:0];
    end
    return r;
  endfunction

  // Eight restoring division steps of a 64-bit shift word by n
  function automatic div_t div_byte(input div_t cur, input logic [MOD_W-1:0] n);
    div_t          d;
    logic [MOD_W:0] t;
    logic          q;
    d = cur;
    for (int j = 0; j < STEP_BITS; j++) begin
      t = {d.rem, d.dv[WIDE_W-1]};
      q = (t >= {1'b0, n});
      if (q) begin
        t = t - {1'b0, n};
      end
      d.rem = t[MOD_W-1:0];
      d.dv  = {d.dv[WIDE_W-2:0], q};
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ src/paillier_encrypt_decrypt_core.sv @@
// ============================================================================
// paillier_encrypt_decrypt_core: pipelined small-key Paillier unit
// Encrypts (g^m * r^n mod n^2) or decrypts (L(c^lambda mod n^2) * mu mod n).
// ============================================================================
//
// Channel  | Dir | Handshake          | Payload
// s_axis   | in  | tvalid/tready      | tuser action, tdata message/blinding/ciphertext
// m_axis   | out | tvalid/tready      | tdata result_value
// cfg      | in  | cfg_we             | cfg_index, cfg_wdata
//
// One request per cycle while the pipeline advances; 81 exponent stages, 18 final
// stages and one output register. Each exponent bit costs a square and a
// multiply, each a multiplier stage plus four 8-bit reduction stages.
// Reset clears valid bits and loads the default key. A stalled output holds
// the pipeline only when its last stage is occupied.
//
`default_nettype none

module paillier_encrypt_decrypt_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [7:0] message, [15:8] blinding, [31:16] ciphertext_in
  input  wire logic [31:0]                      s_axis_tdata,
  // [0] action
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [15:0] result_value
  output logic [15:0]                           m_axis_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [paillier_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [paillier_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import paillier_pkg::*;

  logic [MOD_W-1:0] modulus;
  logic [SQ_W-1:0]  generator;
  logic [MOD_W-1:0] carmichael_lambda;
  logic [MOD_W-1:0] decrypt_factor;
  logic [MOD_W-1:0] key_n;
  logic [SQ_W-1:0]  n_sq;

  exp_st_t ep [0:EXP_STAGES];
  fin_st_t fp [0:FIN_STAGES];
  logic    adv;
  action_t out_action;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus           <= MOD_W'(15);
      generator         <= SQ_W'(16);
      carmichael_lambda <= MOD_W'(4);
      decrypt_factor    <= MOD_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODULUS:   modulus           <= cfg_wdata[MOD_W-1:0];
        REG_GENERATOR: generator         <= cfg_wdata[SQ_W-1:0];
        REG_LAMBDA:    carmichael_lambda <= cfg_wdata[MOD_W-1:0];
        REG_MU:        decrypt_factor    <= cfg_wdata[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign key_n = modulus & KEY_MASK;

  // n squared, settled long before a request reaches a reduction stage
  always_ff @(posedge clk) begin
    n_sq <= SQ_W'(key_n) * SQ_W'(key_n);
  end

  // Advance unless the output holds a result and the last stage is full
  assign adv           = !m_axis_tvalid || m_axis_tready || !fp[FIN_STAGES].valid;
  assign s_axis_tready = adv;

  // Load the first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ep[0].valid <= 1'b0;
    end else if (adv) begin
      ep[0].valid <= s_axis_tvalid;
    end
    if (adv) begin
      ep[0].action <= action_t'(s_axis_tuser);
      if (action_t'(s_axis_tuser) == ACT_DECRYPT) begin
        ep[0].base_a <= s_axis_tdata[31:16];
        ep[0].exp_a  <= carmichael_lambda;
      end else begin
        ep[0].base_a <= generator;
        ep[0].exp_a  <= s_axis_tdata[7:0];
      end
      ep[0].base_b <= s_axis_tdata[15:8];
      ep[0].acc_a  <= SQ_W'(1);
      ep[0].acc_b  <= SQ_W'(1);
      ep[0].prod_a <= '0;
      ep[0].prod_b <= '0;
    end
  end

  // Square-and-multiply stages, most significant exponent bit first
  for (genvar k = 0; k < EXP_STAGES; k++) begin : g_exp
    localparam int RND = k / ROUND_STAGES;
    localparam int PH  = k % ROUND_STAGES;
    localparam int BY  = (PH == 0) ? 0 : ((PH - 1) % MODMUL_STAGES);
    localparam int HI  = PROD_W - 1 - STEP_BITS * BY;
    exp_st_t nx;

    always_comb begin
      nx = ep[k];
      if (PH == 0) begin
        nx.prod_a = PROD_W'(ep[k].acc_a) * PROD_W'(ep[k].acc_a);
        nx.prod_b = PROD_W'(ep[k].acc_b) * PROD_W'(ep[k].acc_b);
        nx.acc_a  = '0;
        nx.acc_b  = '0;
      end else if (PH == MODMUL_STAGES) begin
        nx.prod_a = PROD_W'(ep[k].acc_a) *
                    PROD_W'(ep[k].exp_a[EXP_BITS-1-RND] ? ep[k].base_a : SQ_W'(1));
        nx.prod_b = PROD_W'(ep[k].acc_b) *
                    PROD_W'(key_n[EXP_BITS-1-RND] ? {{(SQ_W-MOD_W){1'b0}}, ep[k].base_b}
                                                  : SQ_W'(1));
        nx.acc_a  = '0;
        nx.acc_b  = '0;
      end else begin
        nx.acc_a = reduce_byte(ep[k].acc_a, ep[k].prod_a[HI -: STEP_BITS], n_sq);
        nx.acc_b = reduce_byte(ep[k].acc_b, ep[k].prod_b[HI -: STEP_BITS], n_sq);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ep[k+1].valid <= 1'b0;
      end else if (adv) begin
        ep[k+1].valid <= nx.valid;
      end
      if (adv) begin
        ep[k+1].action <= nx.action;
        ep[k+1].base_a <= nx.base_a;
        ep[k+1].exp_a  <= nx.exp_a;
        ep[k+1].base_b <= nx.base_b;
        ep[k+1].acc_a  <= nx.acc_a;
        ep[k+1].acc_b  <= nx.acc_b;
        ep[k+1].prod_a <= nx.prod_a;
        ep[k+1].prod_b <= nx.prod_b;
      end
    end
  end

  // Enter the final phase: encrypt product, decrypt x minus one (wraps)
  always_ff @(posedge clk) begin
    if (rst) begin
      fp[0].valid <= 1'b0;
    end else if (adv) begin
      fp[0].valid <= ep[EXP_STAGES].valid;
    end
    if (adv) begin
      fp[0].action <= ep[EXP_STAGES].action;
      fp[0].prod_e <= PROD_W'(ep[EXP_STAGES].acc_a) * PROD_W'(ep[EXP_STAGES].acc_b);
      fp[0].acc_e  <= '0;
      fp[0].dv     <= WIDE_W'(ep[EXP_STAGES].acc_a) - WIDE_W'(1);
      fp[0].rem    <= '0;
    end
  end

  // Divide by n, multiply by mu, reduce modulo n; encrypt reduces alongside
  for (genvar j = 0; j < FIN_STAGES; j++) begin : g_fin
    localparam int HI = PROD_W - 1 - STEP_BITS * ((j < REDUCE_STAGES) ? j : 0);
    fin_st_t nx;
    div_t    dcur;
    div_t    dnew;

    always_comb begin
      nx       = fp[j];
      dcur.rem = fp[j].rem;
      dcur.dv  = fp[j].dv;
      dnew     = div_byte(dcur, key_n);
      if (j < REDUCE_STAGES) begin
        nx.acc_e = reduce_byte(fp[j].acc_e, fp[j].prod_e[HI -: STEP_BITS], n_sq);
      end
      if (j == MUL_STAGE) begin
        nx.dv  = WIDE_W'(fp[j].dv * WIDE_W'(decrypt_factor));
        nx.rem = '0;
      end else begin
        nx.dv  = dnew.dv;
        nx.rem = dnew.rem;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        fp[j+1].valid <= 1'b0;
      end else if (adv) begin
        fp[j+1].valid <= nx.valid;
      end
      if (adv) begin
        fp[j+1].action <= nx.action;
        fp[j+1].acc_e  <= nx.acc_e;
        fp[j+1].prod_e <= nx.prod_e;
        fp[j+1].dv     <= nx.dv;
        fp[j+1].rem    <= nx.rem;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= fp[FIN_STAGES].valid;
    end
    if (!m_axis_tvalid || m_axis_tready) begin
      out_action <= fp[FIN_STAGES].action;
      if (key_n == '0) begin
        m_axis_tdata <= '0;
      end else if (fp[FIN_STAGES].action == ACT_DECRYPT) begin
        m_axis_tdata <= {{(SQ_W-MOD_W){1'b0}}, fp[FIN_STAGES].rem};
      end else begin
        m_axis_tdata <= fp[FIN_STAGES].acc_e;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> ep[0].valid)
    else $error("accepted request missing from first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(ep[EXP_STAGES].valid) && $stable(fp[FIN_STAGES].valid))
    else $error("pipeline moved during stall");

  a_dec_narrow: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_action == ACT_DECRYPT) |-> m_axis_tdata[15:8] == 8'd0)
    else $error("decrypt result exceeds a byte");

  a_enc_reduced: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_action == ACT_ENCRYPT && key_n != '0 && $stable(key_n))
      |-> m_axis_tdata < n_sq)
    else $error("encrypt result not reduced");
`endif

endmodule

`default_nettype wire

@@ tb/sv/paillier_encrypt_decrypt_core_test.sv @@
// ============================================================================
// paillier_encrypt_decrypt_core_test: self-checking bench for the Paillier core
// Streams encrypt and decrypt requests under several keys, predicts each
// result with a behavioral model, and checks results in order with random
// gaps on the input side and random stalls on the output side.
// ============================================================================
`default_nettype none

module paillier_encrypt_decrypt_core_test;
  import paillier_pkg::*;

  typedef struct packed {
    action_t     action;
    logic [7:0]  message;
    logic [7:0]  blinding;
    logic [15:0] ciphertext;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the key
  logic [7:0]  key_n = 8'd15;
  logic [15:0] key_g = 16'd16;
  logic [7:0]  key_lambda = 8'd4;
  logic [7:0]  key_mu = 8'd4;

  request_t    pending_requests[$];
  logic [15:0] expected_results[$];
  request_t    cur_request;
  int          input_gap = 0;
  int          output_stall = 0;
  bit          idle_enable = 1'b1;
  int          error_count = 0;
  int          encrypt_count = 0;
  int          decrypt_count = 0;
  int          key_count = 0;

  paillier_encrypt_decrypt_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Square-and-multiply over a 64-bit exponent window, squaring first
  function automatic longint unsigned pow_mod(longint unsigned base,
                                              longint unsigned expo,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 1;
    for (int i = 63; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (expo[i]) begin
        acc = (acc * base) % m;
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] paillier_result(request_t req);
    longint unsigned n, n2, x, l, res;
    n = key_n;
    n2 = n * n;
    res = 0;
    if (n != 0) begin
      if (req.action == ACT_ENCRYPT) begin
        res = (pow_mod(key_g, req.message, n2) * pow_mod(req.blinding, n, n2)) % n2;
      end else begin
        x = pow_mod(req.ciphertext, key_lambda, n2);
        // zero power wraps modulo 2^64
        l = (x - 1) / n;
        res = (l * key_mu) % n;
      end
    end
    return res[15:0];
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (!idle_enable || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Request driver
  always @(posedge clk) begin
    logic next_valid;
    next_valid = s_axis_tvalid;
    if (s_axis_tvalid && s_axis_tready) begin
      expected_results = {expected_results, paillier_result(cur_request)};
      if (cur_request.action == ACT_ENCRYPT) encrypt_count++;
      else decrypt_count++;
      next_valid = 1'b0;
    end
    if (!(s_axis_tvalid && !s_axis_tready) && !rst) begin
      if (input_gap > 0) begin
        input_gap--;
        next_valid = 1'b0;
      end else if (pending_requests.size() > 0) begin
        cur_request = pending_requests.pop_front();
        s_axis_tdata <= {cur_request.ciphertext, cur_request.blinding, cur_request.message};
        s_axis_tuser <= cur_request.action;
        next_valid = 1'b1;
        input_gap = gap_len();
      end
    end
    s_axis_tvalid <= next_valid;
  end

  // Result monitor
  always @(posedge clk) begin
    logic [15:0] want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result_value %0d", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata !== want) begin
          $error("result_value expected %0d actual %0d", want, m_axis_tdata);
          error_count++;
        end
      end
    end
    if (output_stall > 0) begin
      output_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst;
      output_stall = gap_len();
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODULUS:   key_n = value[7:0];
      REG_GENERATOR: key_g = value;
      REG_LAMBDA:    key_lambda = value[7:0];
      REG_MU:        key_mu = value[7:0];
    endcase
  endtask

  task automatic load_key(logic [7:0] n, logic [15:0] g, logic [7:0] lam, logic [7:0] mu);
    write_reg(REG_MODULUS, {8'd0, n});
    write_reg(REG_GENERATOR, g);
    write_reg(REG_LAMBDA, {8'd0, lam});
    write_reg(REG_MU, {8'd0, mu});
    key_count++;
  endtask

  function automatic request_t make_request(action_t act, logic [7:0] m, logic [7:0] r,
                                            logic [15:0] c);
    request_t req;
    req.action = act;
    req.message = m;
    req.blinding = r;
    req.ciphertext = c;
    return req;
  endfunction

  // Queue one request for the driver
  task automatic queue_request(request_t req);
    pending_requests = {pending_requests, req};
  endtask

  // Random batch: half the decrypts take a genuine ciphertext under this key
  task automatic push_random(int count);
    request_t req;
    for (int i = 0; i < count; i++) begin
      req = make_request(action_t'($urandom_range(1)), 8'($urandom), 8'($urandom),
                         16'($urandom));
      if (req.action == ACT_DECRYPT && $urandom_range(1)) begin
        req.action = ACT_ENCRYPT;
        req.ciphertext = paillier_result(req);
        req.action = ACT_DECRYPT;
      end
      queue_request(req);
    end
  endtask

  // Hold until every request went in and every result came back
  task automatic drain();
    do @(negedge clk);
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (110) @(negedge clk);
  endtask

  initial begin
    int mu_inv;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset key
    queue_request(make_request(ACT_ENCRYPT, 8'd0, 8'd0, 16'd0));
    queue_request(make_request(ACT_ENCRYPT, 8'd255, 8'd255, 16'hFFFF));
    queue_request(make_request(ACT_ENCRYPT, 8'd0, 8'd255, 16'd0));
    queue_request(make_request(ACT_ENCRYPT, 8'd255, 8'd1, 16'd0));
    queue_request(make_request(ACT_ENCRYPT, 8'd7, 8'd2, 16'd0));
    queue_request(make_request(ACT_DECRYPT, 8'd0, 8'd0, 16'd0));
    queue_request(make_request(ACT_DECRYPT, 8'hFF, 8'hFF, 16'hFFFF));
    queue_request(make_request(ACT_DECRYPT, 8'd0, 8'd0, 16'd1));
    queue_request(make_request(ACT_DECRYPT, 8'd0, 8'd0, 16'd225));
    queue_request(make_request(ACT_DECRYPT, 8'd0, 8'd0, 16'd226));
    push_random(80);
    drain();

    // Textbook key: n = 11 * 13, g = n + 1, lambda = 60, mu = 60^-1 mod n
    mu_inv = 0;
    for (int k = 1; k < 143; k++) if ((60 * k) % 143 == 1) mu_inv = k;
    idle_enable = 1'b0;
    load_key(8'd143, 16'd144, 8'd60, mu_inv[7:0]);
    push_random(120);
    drain();
    idle_enable = 1'b1;

    // Upper extremes
    load_key(8'd255, 16'd65024, 8'd255, 8'd255);
    push_random(80);
    queue_request(make_request(ACT_DECRYPT, 8'd0, 8'd0, 16'd0));
    drain();

    // Lower extremes
    load_key(8'd3, 16'd0, 8'd1, 8'd0);
    push_random(60);
    drain();

    // Degenerate moduli: zero, then one with a zero exponent
    load_key(8'd0, 16'hFFFF, 8'd7, 8'd9);
    push_random(30);
    drain();
    load_key(8'd1, 16'd5, 8'd0, 8'd1);
    push_random(30);
    drain();

    // Random keys
    for (int p = 0; p < 8; p++) begin
      idle_enable = (p % 3 != 2);
      load_key(8'($urandom_range(255, 3)), 16'($urandom_range(65535)),
               8'($urandom_range(255, 1)), 8'($urandom_range(255)));
      push_random(50);
      drain();
    end

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end
    $display("Covered %0d encrypt and %0d decrypt requests over %0d key loads.",
             encrypt_count, decrypt_count, key_count);
    if (error_count == 0) begin
      $display("[paillier_encrypt_decrypt_core] OK");
    end else begin
      $display("[paillier_encrypt_decrypt_core] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("[paillier_encrypt_decrypt_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
